/* hdl/slcp_pkg.sv */
// ----------------------------------------------------------------------------
// slcp_pkg
// Shared types and constants for the servo line command parser.
// ----------------------------------------------------------------------------
package slcp_pkg;

   localparam int LINE_LIMIT  = 64;
   localparam int LC_W        = $clog2(LINE_LIMIT + 1);
   localparam int PREFIX_LEN  = 12;
   localparam int NUM_PATS    = 5;
   localparam int VAL_W       = 10;
   localparam int QUEUE_DEPTH = 2;

   // command texts, first character at index 0, padded to the prefix length
   localparam logic [0:NUM_PATS-1][0:PREFIX_LEN-1][7:0] PATS = {
      {"HELLO_PC", 32'h0},
      {"SERVO?", 48'h0},
      {"SERVO:OFF", 24'h0},
      "SERVO:ENABLE",
      "SERVO:ANGLE:"
   };
   localparam logic [0:NUM_PATS-1][3:0] PAT_LEN = {4'd8, 4'd6, 4'd9, 4'd12, 4'd12};
   localparam int PAT_ANGLE = 4;

   localparam logic [7:0] MIN_ANGLE_RST  = 8'd60;
   localparam logic [7:0] MAX_ANGLE_RST  = 8'd150;
   localparam logic [7:0] MAX_STEP_RST   = 8'd5;
   localparam logic [7:0] HOME_ANGLE_RST = 8'd90;
   localparam logic [7:0] CUR_ANGLE_RST  = 8'd90;

   typedef enum logic [1:0] {
      CSR_MIN_ANGLE  = 2'd0,
      CSR_MAX_ANGLE  = 2'd1,
      CSR_MAX_STEP   = 2'd2,
      CSR_HOME_ANGLE = 2'd3
   } csr_index_type;

   typedef enum logic [1:0] {
      RSP_HELLO   = 2'd0,
      RSP_STATUS  = 2'd1,
      RSP_REJECT  = 2'd2,
      RSP_UNKNOWN = 2'd3
   } rsp_kind_type;

   typedef enum logic [2:0] {
      CMD_HELLO     = 3'd0,
      CMD_QUERY     = 3'd1,
      CMD_OFF       = 3'd2,
      CMD_ENABLE    = 3'd3,
      CMD_ANGLE     = 3'd4,
      CMD_ANGLE_BAD = 3'd5,
      CMD_UNKNOWN   = 3'd6
   } cmd_code_type;

   typedef struct packed {
      cmd_code_type      code;
      logic [VAL_W-1:0]  value;
   } cmd_type;

   // queue status seen by the back end
   typedef struct packed {
      logic    valid;
      cmd_type cmd;
   } queue_head_type;

endpackage

/* hdl/slcp_front.sv */
// ----------------------------------------------------------------------------
// slcp_front
// Per-byte line tracking, trimming and incremental pattern matching; emits one
// classified command per completed non-empty line that is not over-long.
// ----------------------------------------------------------------------------
module slcp_front (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  byte_accept,
   input  logic [7:0]            rx_byte,
   output logic                  push,
   output slcp_pkg::cmd_type     push_cmd
);

   typedef struct packed {
      logic [slcp_pkg::NUM_PATS-1:0] alive;
      logic [slcp_pkg::LC_W-1:0]     idx;
      logic [2:0]                    dcount;
      logic [slcp_pkg::VAL_W-1:0]    dval;
      logic                          nondigit;
   } match_type;

   localparam match_type MATCH_CLEAR = '{
      alive: '1, idx: '0, dcount: '0, dval: '0, nondigit: 1'b0};

   logic [slcp_pkg::LC_W-1:0] lc_ff, lc_in;
   logic                      disc_ff, disc_in;
   logic                      started_ff, started_in;
   logic                      space_ff, space_in;
   match_type                 m_ff, m_in, m_sp;
   logic                      is_eol, is_space;
   logic                      hit_found;

   function automatic match_type feed(match_type s, logic [7:0] c);
      match_type r;
      r = s;
      for (int k = 0; k < slcp_pkg::PAT_ANGLE; k++) begin
         if (!(s.idx < slcp_pkg::LC_W'(slcp_pkg::PAT_LEN[k]) &&
               c == slcp_pkg::PATS[k][s.idx[3:0]]))
            r.alive[k] = 1'b0;
      end
      if (s.idx < slcp_pkg::LC_W'(slcp_pkg::PREFIX_LEN)) begin
         if (c != slcp_pkg::PATS[slcp_pkg::PAT_ANGLE][s.idx[3:0]])
            r.alive[slcp_pkg::PAT_ANGLE] = 1'b0;
      end else if (c >= 8'd48 && c <= 8'd57) begin
         if (s.dcount < 3'd3)
            r.dval = slcp_pkg::VAL_W'(s.dval * 10'd10 + 10'(c[3:0]));
         if (s.dcount < 3'd7)
            r.dcount = s.dcount + 3'd1;
      end else begin
         r.nondigit = 1'b1;
      end
      r.idx = s.idx + slcp_pkg::LC_W'(1);
      return r;
   endfunction

   assign is_eol   = (rx_byte == 8'd10) || (rx_byte == 8'd13);
   assign is_space = (rx_byte == 8'd32) || (rx_byte == 8'd9) ||
                     (rx_byte == 8'd11) || (rx_byte == 8'd12);

   // a pending inner whitespace run is matched as one space
   always_comb begin
      m_sp = space_ff ? feed(m_ff, 8'd32) : m_ff;
   end

   always_comb begin
      lc_in      = lc_ff;
      disc_in    = disc_ff;
      started_in = started_ff;
      space_in   = space_ff;
      m_in       = m_ff;
      if (byte_accept) begin
         if (is_eol) begin
            lc_in      = '0;
            disc_in    = 1'b0;
            started_in = 1'b0;
            space_in   = 1'b0;
            m_in       = MATCH_CLEAR;
         end else if (disc_ff) begin
            disc_in = 1'b1;
         end else if (lc_ff >= slcp_pkg::LC_W'(slcp_pkg::LINE_LIMIT)) begin
            lc_in      = '0;
            disc_in    = 1'b1;
            started_in = 1'b0;
            space_in   = 1'b0;
            m_in       = MATCH_CLEAR;
         end else begin
            lc_in = lc_ff + slcp_pkg::LC_W'(1);
            if (is_space) begin
               if (started_ff) space_in = 1'b1;
            end else begin
               space_in   = 1'b0;
               started_in = 1'b1;
               m_in       = feed(m_sp, rx_byte);
            end
         end
      end
   end

   // line-end classification from the match state
   always_comb begin
      push_cmd.code  = slcp_pkg::CMD_UNKNOWN;
      push_cmd.value = m_ff.dval;
      hit_found      = 1'b0;
      for (int k = 0; k < slcp_pkg::PAT_ANGLE; k++) begin
         if (!hit_found && m_ff.alive[k] &&
             m_ff.idx == slcp_pkg::LC_W'(slcp_pkg::PAT_LEN[k])) begin
            hit_found     = 1'b1;
            push_cmd.code = slcp_pkg::cmd_code_type'(3'(k));
         end
      end
      if (!hit_found && m_ff.alive[slcp_pkg::PAT_ANGLE] &&
          m_ff.idx >= slcp_pkg::LC_W'(slcp_pkg::PREFIX_LEN)) begin
         if (!m_ff.nondigit && (m_ff.dcount == 3'd2 || m_ff.dcount == 3'd3))
            push_cmd.code = slcp_pkg::CMD_ANGLE;
         else
            push_cmd.code = slcp_pkg::CMD_ANGLE_BAD;
      end
   end

   assign push = byte_accept && is_eol && !disc_ff && started_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         lc_ff      <= '0;
         disc_ff    <= 1'b0;
         started_ff <= 1'b0;
         space_ff   <= 1'b0;
         m_ff       <= MATCH_CLEAR;
      end else begin
         lc_ff      <= lc_in;
         disc_ff    <= disc_in;
         started_ff <= started_in;
         space_ff   <= space_in;
         m_ff       <= m_in;
      end
   end

endmodule

/* hdl/slcp_queue.sv */
// ----------------------------------------------------------------------------
// slcp_queue
// Short command queue between the front and back ends.
// ----------------------------------------------------------------------------
module slcp_queue (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        push,
   input  slcp_pkg::cmd_type           push_cmd,
   input  logic                        pop,
   output logic                        full,
   output slcp_pkg::queue_head_type    head
);

   localparam int PTR_W = (slcp_pkg::QUEUE_DEPTH > 1) ? $clog2(slcp_pkg::QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(slcp_pkg::QUEUE_DEPTH + 1);

   slcp_pkg::cmd_type  entry_ff [slcp_pkg::QUEUE_DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic               do_push, do_pop;

   assign full     = (count_ff == CNT_W'(slcp_pkg::QUEUE_DEPTH));
   assign do_push  = push && !full;
   assign do_pop   = pop && (count_ff != '0);
   assign head.valid = (count_ff != '0);
   assign head.cmd   = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push)
         wr_ptr_in = (wr_ptr_ff == PTR_W'(slcp_pkg::QUEUE_DEPTH - 1)) ? '0
                     : wr_ptr_ff + PTR_W'(1);
      if (do_pop)
         rd_ptr_in = (rd_ptr_ff == PTR_W'(slcp_pkg::QUEUE_DEPTH - 1)) ? '0
                     : rd_ptr_ff + PTR_W'(1);
      if (do_push && !do_pop)
         count_in = count_ff + CNT_W'(1);
      else if (do_pop && !do_push)
         count_in = count_ff - CNT_W'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push)
         entry_ff[wr_ptr_ff] <= push_cmd;
   end

endmodule

/* hdl/slcp_back.sv */
// ----------------------------------------------------------------------------
// slcp_back
// Executes queued commands against the servo state and holds the result in
// the output register. Also holds the limit registers.
// ----------------------------------------------------------------------------
module slcp_back (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        csr_write,
   input  logic [1:0]                  csr_index,
   input  logic [7:0]                  csr_data,
   input  slcp_pkg::queue_head_type    head,
   output logic                        pop,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic [1:0]                  rsp_response_kind,
   output logic                        rsp_servo_on,
   output logic [7:0]                  rsp_servo_angle_out
);

   logic [7:0]                min_ff, max_ff, step_ff, home_ff;
   logic                      en_ff, en_in;
   logic [7:0]                cur_ff, cur_in;
   logic                      valid_ff, valid_in;
   slcp_pkg::rsp_kind_type    kind_ff, kind_in;
   logic [slcp_pkg::VAL_W-1:0] req, diff;
   logic                      angle_ok;

   assign req  = head.cmd.value;
   assign diff = (req > slcp_pkg::VAL_W'(cur_ff)) ? req - slcp_pkg::VAL_W'(cur_ff)
                                                  : slcp_pkg::VAL_W'(cur_ff) - req;
   assign angle_ok = en_ff && (req >= slcp_pkg::VAL_W'(min_ff)) &&
                     (req <= slcp_pkg::VAL_W'(max_ff)) &&
                     (diff <= slcp_pkg::VAL_W'(step_ff));

   assign pop = head.valid && (!valid_ff || !rsp_stall);

   always_comb begin
      en_in    = en_ff;
      cur_in   = cur_ff;
      kind_in  = kind_ff;
      valid_in = valid_ff && rsp_stall;
      if (pop) begin
         valid_in = 1'b1;
         unique case (head.cmd.code)
            slcp_pkg::CMD_HELLO: kind_in = slcp_pkg::RSP_HELLO;
            slcp_pkg::CMD_QUERY: kind_in = slcp_pkg::RSP_STATUS;
            slcp_pkg::CMD_OFF: begin
               en_in   = 1'b0;
               kind_in = slcp_pkg::RSP_STATUS;
            end
            slcp_pkg::CMD_ENABLE: begin
               // homing only happens when coming up from off
               if (!en_ff) begin
                  en_in  = 1'b1;
                  cur_in = home_ff;
               end
               kind_in = slcp_pkg::RSP_STATUS;
            end
            slcp_pkg::CMD_ANGLE: begin
               if (angle_ok) begin
                  cur_in  = req[7:0];
                  kind_in = slcp_pkg::RSP_STATUS;
               end else begin
                  kind_in = slcp_pkg::RSP_REJECT;
               end
            end
            slcp_pkg::CMD_ANGLE_BAD: kind_in = slcp_pkg::RSP_REJECT;
            default: kind_in = slcp_pkg::RSP_UNKNOWN;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         min_ff  <= slcp_pkg::MIN_ANGLE_RST;
         max_ff  <= slcp_pkg::MAX_ANGLE_RST;
         step_ff <= slcp_pkg::MAX_STEP_RST;
         home_ff <= slcp_pkg::HOME_ANGLE_RST;
      end else if (csr_write) begin
         unique case (slcp_pkg::csr_index_type'(csr_index))
            slcp_pkg::CSR_MIN_ANGLE:  min_ff  <= csr_data;
            slcp_pkg::CSR_MAX_ANGLE:  max_ff  <= csr_data;
            slcp_pkg::CSR_MAX_STEP:   step_ff <= csr_data;
            slcp_pkg::CSR_HOME_ANGLE: home_ff <= csr_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         en_ff    <= 1'b0;
         cur_ff   <= slcp_pkg::CUR_ANGLE_RST;
         valid_ff <= 1'b0;
      end else begin
         en_ff    <= en_in;
         cur_ff   <= cur_in;
         valid_ff <= valid_in;
      end
   end

   // result payload, loaded together with the state update
   logic       on_ff;
   logic [7:0] angle_ff;

   always_ff @(posedge clock) begin
      if (pop) begin
         kind_ff  <= kind_in;
         on_ff    <= en_in;
         angle_ff <= cur_in;
      end
   end

   assign rsp_valid           = valid_ff;
   assign rsp_response_kind   = kind_ff;
   assign rsp_servo_on        = on_ff;
   assign rsp_servo_angle_out = angle_ff;

endmodule

/* hdl/servo_line_command_parser.sv */
// ----------------------------------------------------------------------------
// servo_line_command_parser
// Line-oriented ASCII servo command parser, top level.
// ----------------------------------------------------------------------------
// Takes one received byte per cycle; CR or LF ends a line and every non-empty,
// not over-long line yields one response transaction. The front end matches
// each byte as it arrives, so a line end is classified in the cycle it is
// taken and queued; from the queue the back end takes it once the output
// register is empty or not stalled, executes it and loads the result. The
// input stalls only while the two-entry command queue is full, which happens
// when the response side holds off for several line ends in a row. The limit
// registers are plain writes, taken whenever csr_write is high.
module servo_line_command_parser (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_rx_byte,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_response_kind,
   output logic        rsp_servo_on,
   output logic [7:0]  rsp_servo_angle_out,
   input  logic        csr_write,
   input  logic [1:0]  csr_index,
   input  logic [7:0]  csr_data
);

   logic                       byte_accept;
   logic                       push, pop, full;
   slcp_pkg::cmd_type          push_cmd;
   slcp_pkg::queue_head_type   head;

   assign req_stall   = full;
   assign byte_accept = req_valid && !full;

   slcp_front u_front (
      .clock       (clock),
      .reset       (reset),
      .byte_accept (byte_accept),
      .rx_byte     (req_rx_byte),
      .push        (push),
      .push_cmd    (push_cmd)
   );

   slcp_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_cmd (push_cmd),
      .pop      (pop),
      .full     (full),
      .head     (head)
   );

   slcp_back u_back (
      .clock               (clock),
      .reset               (reset),
      .csr_write           (csr_write),
      .csr_index           (csr_index),
      .csr_data            (csr_data),
      .head                (head),
      .pop                 (pop),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_response_kind   (rsp_response_kind),
      .rsp_servo_on        (rsp_servo_on),
      .rsp_servo_angle_out (rsp_servo_angle_out)
   );

endmodule

/* hdl/slcp_checker.sv */
// ----------------------------------------------------------------------------
// slcp_checker
// Port-level checks on the servo line command parser, bound to the top level.
// ----------------------------------------------------------------------------
module slcp_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_stall,
   input  logic [7:0]  req_rx_byte,
   input  logic        rsp_valid,
   input  logic        rsp_stall,
   input  logic [1:0]  rsp_response_kind,
   input  logic        rsp_servo_on,
   input  logic [7:0]  rsp_servo_angle_out,
   input  logic        csr_write,
   input  logic [1:0]  csr_index,
   input  logic [7:0]  csr_data
);

   // a stalled response transaction holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_response_kind) &&
      $stable(rsp_servo_on) && $stable(rsp_servo_angle_out))
      else $error("response changed while stalled");

   // reset empties the output register
   a_rst_rsp: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid after reset");

   // reset empties the command queue, so input is taken at once
   a_rst_req: assert property (@(posedge clock) reset |=> !req_stall)
      else $error("input stalled after reset");

   // a fresh response follows a line end or a queued command; a line end
   // taken as reset ends passes the queue and the output register first
   a_rst_two: assert property (@(posedge clock) reset ##1 !reset |=> !rsp_valid)
      else $error("response without any line end");

endmodule

bind servo_line_command_parser slcp_checker u_slcp_checker (.*);
